// File: rtl/core/keyboard_scancode_to_ascii_fifo_assert.svh
// assertion macros for the keyboard translator rtl
// needs nothing else; included by kbd_ctrl, which checks its own logic
`ifndef KEYBOARD_SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// same-cycle implication under active-low reset
`define KBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbd assertion failed");

// next-cycle implication under active-low reset
`define KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbd assertion failed");

`endif

// File: rtl/core/kbd_pkg.sv
// shared types, scancode constants and key map for the keyboard translator
// no dependencies; used by kbd_ctrl, kbd_dp and the top level
package kbd_pkg;

    localparam int OUT_W = 16;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_UP           = 8'h48;
    localparam logic [7:0] SC_DOWN         = 8'h50;
    localparam logic [7:0] SC_LEFT         = 8'h4B;
    localparam logic [7:0] SC_RIGHT        = 8'h4D;

    localparam logic [7:0] CH_UP    = 8'h80;
    localparam logic [7:0] CH_DOWN  = 8'h81;
    localparam logic [7:0] CH_LEFT  = 8'h82;
    localparam logic [7:0] CH_RIGHT = 8'h83;

    typedef struct packed {
        logic capture;  // latch the accepted item
        logic exec;     // update fifo and shift state
        logic load;     // move the result into the output register
    } cmd_t;

    // us layout, set 1 make codes; zero means no character
    function automatic logic [7:0] key_map(input logic shift, input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = shift ? 8'h21 : 8'h31;
            7'd3:    ch = shift ? 8'h40 : 8'h32;
            7'd4:    ch = shift ? 8'h23 : 8'h33;
            7'd5:    ch = shift ? 8'h24 : 8'h34;
            7'd6:    ch = shift ? 8'h25 : 8'h35;
            7'd7:    ch = shift ? 8'h5E : 8'h36;
            7'd8:    ch = shift ? 8'h26 : 8'h37;
            7'd9:    ch = shift ? 8'h2A : 8'h38;
            7'd10:   ch = shift ? 8'h28 : 8'h39;
            7'd11:   ch = shift ? 8'h29 : 8'h30;
            7'd12:   ch = shift ? 8'h5F : 8'h2D;
            7'd13:   ch = shift ? 8'h2B : 8'h3D;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = shift ? 8'h51 : 8'h71;
            7'd17:   ch = shift ? 8'h57 : 8'h77;
            7'd18:   ch = shift ? 8'h45 : 8'h65;
            7'd19:   ch = shift ? 8'h52 : 8'h72;
            7'd20:   ch = shift ? 8'h54 : 8'h74;
            7'd21:   ch = shift ? 8'h59 : 8'h79;
            7'd22:   ch = shift ? 8'h55 : 8'h75;
            7'd23:   ch = shift ? 8'h49 : 8'h69;
            7'd24:   ch = shift ? 8'h4F : 8'h6F;
            7'd25:   ch = shift ? 8'h50 : 8'h70;
            7'd26:   ch = shift ? 8'h7B : 8'h5B;
            7'd27:   ch = shift ? 8'h7D : 8'h5D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = shift ? 8'h41 : 8'h61;
            7'd31:   ch = shift ? 8'h53 : 8'h73;
            7'd32:   ch = shift ? 8'h44 : 8'h64;
            7'd33:   ch = shift ? 8'h46 : 8'h66;
            7'd34:   ch = shift ? 8'h47 : 8'h67;
            7'd35:   ch = shift ? 8'h48 : 8'h68;
            7'd36:   ch = shift ? 8'h4A : 8'h6A;
            7'd37:   ch = shift ? 8'h4B : 8'h6B;
            7'd38:   ch = shift ? 8'h4C : 8'h6C;
            7'd39:   ch = shift ? 8'h3A : 8'h3B;
            7'd40:   ch = shift ? 8'h22 : 8'h27;
            7'd41:   ch = shift ? 8'h7E : 8'h60;
            7'd43:   ch = shift ? 8'h7C : 8'h5C;
            7'd44:   ch = shift ? 8'h5A : 8'h7A;
            7'd45:   ch = shift ? 8'h58 : 8'h78;
            7'd46:   ch = shift ? 8'h43 : 8'h63;
            7'd47:   ch = shift ? 8'h56 : 8'h76;
            7'd48:   ch = shift ? 8'h42 : 8'h62;
            7'd49:   ch = shift ? 8'h4E : 8'h6E;
            7'd50:   ch = shift ? 8'h4D : 8'h6D;
            7'd51:   ch = shift ? 8'h3C : 8'h2C;
            7'd52:   ch = shift ? 8'h3E : 8'h2E;
            7'd53:   ch = shift ? 8'h3F : 8'h2F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/kbd_dp.sv
// datapath: item latch, shift flag, character ring buffer and output register
// depends on kbd_pkg; driven by commands from kbd_ctrl
module kbd_dp #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kbd_pkg::cmd_t             cmd,
    input  logic                      in_action,
    input  logic [7:0]                in_code,
    output logic [kbd_pkg::OUT_W-1:0] out_data
);

    localparam int PTR_W = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rdata_reg;

    logic             action_reg;
    logic [7:0]       code_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             shift_reg, shift_next;
    logic             hit_reg, hit_next;
    logic             lost_reg, lost_next;
    logic [kbd_pkg::OUT_W-1:0] out_reg;

    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic             fifo_empty, fifo_full;
    logic [7:0]       push_char;
    logic             do_write, do_read;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);
    assign fifo_full  = (wr_ptr_inc == rd_ptr_reg);

    // character for a make code; zero pushes nothing
    always_comb
    begin
        case (code_reg)
            kbd_pkg::SC_UP:    push_char = kbd_pkg::CH_UP;
            kbd_pkg::SC_DOWN:  push_char = kbd_pkg::CH_DOWN;
            kbd_pkg::SC_LEFT:  push_char = kbd_pkg::CH_LEFT;
            kbd_pkg::SC_RIGHT: push_char = kbd_pkg::CH_RIGHT;
            default:           push_char = kbd_pkg::key_map(shift_reg, code_reg[6:0]);
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        shift_next  = shift_reg;
        hit_next    = hit_reg;
        lost_next   = lost_reg;
        do_write    = 1'b0;
        do_read     = 1'b0;
        if (cmd.exec)
        begin
            hit_next  = 1'b0;
            lost_next = 1'b0;
            if (action_reg)
            begin
                if (!fifo_empty)
                begin
                    do_read     = 1'b1;
                    hit_next    = 1'b1;
                    rd_ptr_next = rd_ptr_inc;
                end
            end
            else if (code_reg inside {kbd_pkg::SC_LSHIFT_MAKE, kbd_pkg::SC_RSHIFT_MAKE})
            begin
                shift_next = 1'b1;
            end
            else if (code_reg inside {kbd_pkg::SC_LSHIFT_BREAK, kbd_pkg::SC_RSHIFT_BREAK})
            begin
                shift_next = 1'b0;
            end
            else if (!code_reg[7] && (push_char != 8'h00))
            begin
                if (fifo_full)
                begin
                    lost_next = 1'b1;
                end
                else
                begin
                    do_write    = 1'b1;
                    wr_ptr_next = wr_ptr_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            shift_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            lost_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            shift_reg  <= shift_next;
            hit_reg    <= hit_next;
            lost_reg   <= lost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= push_char;
        end
        if (do_read)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            code_reg   <= in_code;
        end
        // pointers already reflect this item when the result is loaded
        if (cmd.load)
        begin
            out_reg <= {5'b0, lost_reg, !fifo_empty,
                        (hit_reg ? rdata_reg : 8'h00), hit_reg};
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/core/kbd_ctrl.sv
// controller: sequences capture, execute and load, owns both handshakes
// depends on kbd_pkg and keyboard_scancode_to_ascii_fifo_assert.svh
`include "keyboard_scancode_to_ascii_fifo_assert.svh"

module kbd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output kbd_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // wait here until the previous item has left the output register
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `KBD_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `KBD_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_reg == ST_EXEC)
    `KBD_ASSERT_NEXT(a_exec_load, clk, rst_n, cmd.exec, state_reg == ST_LOAD)
    `KBD_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.load, out_valid && in_ready)

endmodule

// File: rtl/core/keyboard_scancode_to_ascii_fifo.sv
// an accepted item is executed, then its result is loaded into the output register and offered
// a new item is taken only after capture, execute and load; load waits until the last result is taken
// a pop reads the character buffer through its registered read port during execute
// reset: asynchronous, clears pointers, shift flag and control; the buffer is not cleared
// and needs no clearing pass, so items are taken from the first cycle after reset
module keyboard_scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // [7:0] scancode
    input  logic                      s_axis_tuser,  // [0] action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] read_valid, [8:1] read_char, [9] has_key, [10] dropped, rest zero
    output logic [kbd_pkg::OUT_W-1:0] m_axis_tdata
);

    kbd_pkg::cmd_t cmd;

    kbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    kbd_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_action (s_axis_tuser),
        .in_code   (s_axis_tdata),
        .out_data  (m_axis_tdata)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for keyboard_scancode_to_ascii_fifo: scancode and pop items in, one result item out
// depends on kbd_pkg and the rtl top level; tracks shift state and the character fifo on its own
module tb_top;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 12;
    localparam int MAX_REPORT = 10;
    localparam int KEY_COUNT  = 58;
    localparam int RANDOM_ITEMS = 830;

    // a few ordinary make codes for the directed part
    localparam logic [7:0] SC_ESC   = 8'h01;
    localparam logic [7:0] SC_ONE   = 8'h02;
    localparam logic [7:0] SC_A     = 8'h1E;
    localparam logic [7:0] SC_SLASH = 8'h35;

    typedef enum logic {
        ACT_KEY = 1'b0,
        ACT_POP = 1'b1
    } kbd_action_e;

    // same layout as m_axis_tdata, read_valid in bit 0
    typedef struct packed {
        logic [4:0] pad;
        logic       dropped;
        logic       has_key;
        logic [7:0] read_char;
        logic       read_valid;
    } kbd_result_t;

    // us layout, index 0 leftmost
    localparam logic [KEY_COUNT*8-1:0] PLAIN_KEYS = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    localparam logic [KEY_COUNT*8-1:0] SHIFTED_KEYS = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [7:0]        in_code = 8'h00;
    logic              in_action = 1'b0;
    logic              out_ready = 1'b0;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [kbd_pkg::OUT_W-1:0] m_axis_tdata;

    // translator state as the block should hold it
    logic [7:0]   char_buf [0:DEPTH-1];
    int unsigned  wr_ptr = 0;
    int unsigned  rd_ptr = 0;
    logic         shift_down = 1'b0;

    kbd_result_t  results_due[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int unsigned  ready_phase = 0;
    int           items_sent = 0;
    int           pops_sent = 0;
    int           chars_popped = 0;
    int           chars_dropped = 0;
    int           results_seen = 0;
    int           peak_level = 0;

    keyboard_scancode_to_ascii_fifo #(
        .FIFO_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(in_code),
        .s_axis_tuser(in_action),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(out_ready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] key_char(logic shifted, logic [6:0] idx);
        if (idx >= KEY_COUNT)
            return 8'h00;
        if (shifted)
            return SHIFTED_KEYS[(KEY_COUNT-1-idx)*8 +: 8];
        return PLAIN_KEYS[(KEY_COUNT-1-idx)*8 +: 8];
    endfunction

    function automatic int fifo_level();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    // advances the translator state by one accepted item and returns its result
    function automatic kbd_result_t translate_key_item(kbd_action_e act, logic [7:0] code);
        kbd_result_t r;
        logic [7:0]  ch;
        int unsigned nxt;
        r = '0;
        ch = 8'h00;
        if (act == ACT_POP) begin
            if (wr_ptr != rd_ptr) begin
                r.read_valid = 1'b1;
                r.read_char = char_buf[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
            end
        end else if (code == kbd_pkg::SC_LSHIFT_MAKE || code == kbd_pkg::SC_RSHIFT_MAKE) begin
            shift_down = 1'b1;
        end else if (code == kbd_pkg::SC_LSHIFT_BREAK
                     || code == kbd_pkg::SC_RSHIFT_BREAK) begin
            shift_down = 1'b0;
        end else if (!code[7]) begin
            case (code)
                kbd_pkg::SC_UP:    ch = kbd_pkg::CH_UP;
                kbd_pkg::SC_DOWN:  ch = kbd_pkg::CH_DOWN;
                kbd_pkg::SC_LEFT:  ch = kbd_pkg::CH_LEFT;
                kbd_pkg::SC_RIGHT: ch = kbd_pkg::CH_RIGHT;
                default:           ch = key_char(shift_down, code[6:0]);
            endcase
            if (ch != 8'h00) begin
                nxt = (wr_ptr + 1) % DEPTH;
                if (nxt == rd_ptr) begin
                    r.dropped = 1'b1;
                end else begin
                    char_buf[wr_ptr] = ch;
                    wr_ptr = nxt;
                end
            end
        end
        r.has_key = (wr_ptr != rd_ptr);
        return r;
    endfunction

    // a make code that yields a character
    function automatic logic [7:0] random_key();
        logic [7:0] code;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       code = kbd_pkg::SC_UP;
                1:       code = kbd_pkg::SC_DOWN;
                2:       code = kbd_pkg::SC_LEFT;
                default: code = kbd_pkg::SC_RIGHT;
            endcase
            return code;
        end
        do
            code = 8'($urandom_range(1, KEY_COUNT - 1));
        while (key_char(1'b0, code[6:0]) == 8'h00);
        return code;
    endfunction

    function automatic logic [7:0] random_shift(logic make);
        if ($urandom_range(0, 1) == 0)
            return make ? kbd_pkg::SC_LSHIFT_MAKE : kbd_pkg::SC_LSHIFT_BREAK;
        return make ? kbd_pkg::SC_RSHIFT_MAKE : kbd_pkg::SC_RSHIFT_BREAK;
    endfunction

    task automatic send_item(kbd_action_e act, logic [7:0] code);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                in_code <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_action <= act;
        in_code <= code;
        do
            @(posedge clk);
        while (!s_axis_tready);
        results_due.push_back(translate_key_item(act, code));
        items_sent++;
        if (act == ACT_POP)
            pops_sent++;
        if (fifo_level() > peak_level)
            peak_level = fifo_level();
    endtask

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORT)
            $display("mismatch on result %0d: %s expected 0x%0h got 0x%0h",
                     results_seen, what, want, got);
    endtask

    // receiver: always ready, random stalls, then a fixed stall pattern, in turn
    always @(negedge clk) begin
        ready_phase <= ready_phase + 1;
        case ((ready_phase / 256) % 3)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ((ready_phase % 9) < 4);
        endcase
    end

    always @(posedge clk) begin : result_check
        kbd_result_t got;
        kbd_result_t want;
        if (rst_n) begin
            if ((in_valid && s_axis_tready) || (m_axis_tvalid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && out_ready) begin
                got = m_axis_tdata;
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected item", 16'h0, got);
                end else begin
                    want = results_due.pop_front();
                    if (got.read_valid != want.read_valid)
                        report_mismatch("read_valid", want.read_valid, got.read_valid);
                    if (got.read_char != want.read_char)
                        report_mismatch("read_char", want.read_char, got.read_char);
                    if (got.has_key != want.has_key)
                        report_mismatch("has_key", want.has_key, got.has_key);
                    if (got.dropped != want.dropped)
                        report_mismatch("dropped", want.dropped, got.dropped);
                    if (got.pad != want.pad)
                        report_mismatch("unused bits", want.pad, got.pad);
                    if (want.read_valid)
                        chars_popped++;
                    if (want.dropped)
                        chars_dropped++;
                end
                results_seen++;
            end
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, results_due.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // special cases one by one: empty pop, ignored codes, arrows, both shifts
    task automatic test_directed();
        send_item(ACT_POP, 8'hFF);
        send_item(ACT_KEY, 8'h00);
        send_item(ACT_KEY, 8'h80);
        send_item(ACT_KEY, 8'hFF);
        send_item(ACT_KEY, kbd_pkg::SC_UP);
        send_item(ACT_KEY, kbd_pkg::SC_DOWN);
        send_item(ACT_KEY, kbd_pkg::SC_LEFT);
        send_item(ACT_KEY, kbd_pkg::SC_RIGHT);
        send_item(ACT_KEY, SC_A);
        send_item(ACT_KEY, kbd_pkg::SC_LSHIFT_MAKE);
        send_item(ACT_KEY, SC_ONE);
        send_item(ACT_KEY, kbd_pkg::SC_LSHIFT_BREAK);
        send_item(ACT_KEY, kbd_pkg::SC_RSHIFT_MAKE);
        send_item(ACT_KEY, SC_SLASH);
        send_item(ACT_KEY, kbd_pkg::SC_RSHIFT_BREAK);
        send_item(ACT_KEY, SC_ESC);
        // pops carry codes that must be ignored; the last one finds the fifo empty
        send_item(ACT_POP, 8'h00);
        send_item(ACT_POP, 8'h7F);
        send_item(ACT_POP, kbd_pkg::SC_LSHIFT_MAKE);
        send_item(ACT_POP, kbd_pkg::SC_RSHIFT_BREAK);
        send_item(ACT_POP, 8'h80);
        send_item(ACT_POP, SC_A);
        send_item(ACT_POP, 8'hFF);
        send_item(ACT_POP, 8'h55);
        send_item(ACT_POP, 8'hAA);
    endtask

    // sender holds off until every result is back
    task automatic test_drain_pause();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        wait (results_due.size() == 0);
    endtask

    task automatic test_fill_and_overflow();
        while (fifo_level() < DEPTH - 1) begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_KEY, random_shift(1'($urandom_range(0, 1))));
            else
                send_item(ACT_KEY, random_key());
        end
        repeat (4) send_item(ACT_KEY, random_key());
        // one pop frees one slot: the next push fits, the one after is lost
        send_item(ACT_POP, 8'($urandom));
        send_item(ACT_KEY, random_key());
        send_item(ACT_KEY, random_key());
        while (fifo_level() > 0)
            send_item(ACT_POP, 8'($urandom));
        send_item(ACT_POP, 8'($urandom));
        send_item(ACT_KEY, random_shift(1'b0));
    endtask

    // mostly typed words with shift held around some, pop runs, plus noise
    task automatic test_random_typing();
        int stop_at;
        int n;
        logic shifted;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    shifted = ($urandom_range(0, 2) == 0);
                    if (shifted)
                        send_item(ACT_KEY, random_shift(1'b1));
                    n = $urandom_range(1, 8);
                    repeat (n) send_item(ACT_KEY, random_key());
                    if (shifted)
                        send_item(ACT_KEY, random_shift(1'b0));
                end
                5, 6, 7: begin
                    n = $urandom_range(1, fifo_level() / 8 + 6);
                    repeat (n) send_item(ACT_POP, 8'($urandom));
                end
                8: begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(kbd_action_e'($urandom_range(0, 1)), 8'($urandom));
                end
                default: begin
                    // broken sequences: shift press with no release, stray breaks
                    if ($urandom_range(0, 1) == 0)
                        send_item(ACT_KEY, random_shift(1'b1));
                    else
                        send_item(ACT_KEY, random_key() | 8'h80);
                end
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_drain_pause();
        test_fill_and_overflow();
        test_drain_pause();
        test_random_typing();

        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d items (%0d pops), %0d characters popped, %0d lost to a full fifo",
                 items_sent, pops_sent, chars_popped, chars_dropped);
        $display("fifo peaked at %0d of %0d entries, %0d mismatches",
                 peak_level, DEPTH - 1, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/kbd_pkg.sv
rtl/core/kbd_dp.sv
rtl/core/kbd_ctrl.sv
rtl/core/keyboard_scancode_to_ascii_fifo.sv
bench/tb_top.sv
